// ===== src/click_rate_gate_assert.svh =====
// ----------------------------------------------------------------------------
// Click rate gate assertion macros
// Short forms for the concurrent checks used in the click rate gate.
// ----------------------------------------------------------------------------
`ifndef CLICK_RATE_GATE_ASSERT_SVH
`define CLICK_RATE_GATE_ASSERT_SVH

// Same-cycle implication, sampled on clk and muted while rst_n is low.
`define CRG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("click_rate_gate: same-cycle check failed");

// Next-cycle implication, sampled on clk and muted while rst_n is low.
`define CRG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("click_rate_gate: next-cycle check failed");

`endif

// ===== src/crg_pkg.sv =====
// ----------------------------------------------------------------------------
// Click rate gate package
// Types, register map, reset values and the wrapping gap helper.
// ----------------------------------------------------------------------------
package crg_pkg;

  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned REG_IX_W = 3;

  // Register indexes (byte address is four times the index).
  localparam logic [REG_IX_W-1:0] REG_DOUBLE_CLICK = 3'd0;
  localparam logic [REG_IX_W-1:0] REG_TOL_X        = 3'd1;
  localparam logic [REG_IX_W-1:0] REG_TOL_Y        = 3'd2;
  localparam logic [REG_IX_W-1:0] REG_ORDER_ON     = 3'd3;
  localparam logic [REG_IX_W-1:0] REG_ORDER_GAP    = 3'd4;

  localparam logic [15:0] DOUBLE_CLICK_RST = 16'd500;
  localparam logic [7:0]  TOL_RST          = 8'd5;
  localparam logic        ORDER_ON_RST     = 1'b1;
  localparam logic [15:0] ORDER_GAP_RST    = 16'd100;

  // Request kinds.
  localparam logic FUNC_MOVE  = 1'b0;
  localparam logic FUNC_PRESS = 1'b1;

  typedef struct packed {
    logic [15:0] double_click_ms;
    logic [7:0]  tolerance_x;
    logic [7:0]  tolerance_y;
    logic        order_guard_on;
    logic [15:0] order_gap_ms;
  } cfg_t;

  typedef struct packed {
    logic        accepted;
    logic [15:0] wait_ms;
  } res_t;

  // Remaining wait of a gap measured with wrapping time, zero once it has passed.
  function automatic logic [15:0] gap_wait(input logic [31:0] now,
                                           input logic [31:0] since,
                                           input logic [15:0] gap);
    logic [31:0] elapsed;
    logic [31:0] remain;
    elapsed = now - since;
    remain  = {16'd0, gap} - elapsed;
    if (elapsed < {16'd0, gap}) begin
      return remain[15:0];
    end
    return 16'd0;
  endfunction

endpackage

// ===== src/crg_in_if.sv =====
// ----------------------------------------------------------------------------
// Click rate gate input channel
// Valid/ready channel carrying pointer moves and presses.
// ----------------------------------------------------------------------------
interface crg_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic               is_mouse;
  logic               block_double;
  logic [31:0]        now_ms;

  modport source (output valid, func, pos_x, pos_y, is_mouse, block_double, now_ms,
                  input ready);
  modport sink (input valid, func, pos_x, pos_y, is_mouse, block_double, now_ms,
                output ready);
endinterface

// ===== src/crg_out_if.sv =====
// ----------------------------------------------------------------------------
// Click rate gate result channel
// Valid/ready channel carrying the decision for each press.
// ----------------------------------------------------------------------------
interface crg_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [15:0] wait_ms;

  modport source (output valid, accepted, wait_ms, input ready);
  modport sink (input valid, accepted, wait_ms, output ready);
endinterface

// ===== src/crg_cfg.sv =====
// ----------------------------------------------------------------------------
// Click rate gate register bank
// APB-style register file holding the gate timings and tolerances.
// ----------------------------------------------------------------------------
module crg_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [crg_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output crg_pkg::cfg_t              cfg
);

  crg_pkg::cfg_t                cfg_r;
  logic [crg_pkg::REG_IX_W-1:0] ix;
  logic                         wr_en;

  assign ix     = paddr[crg_pkg::ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.double_click_ms <= crg_pkg::DOUBLE_CLICK_RST;
      cfg_r.tolerance_x     <= crg_pkg::TOL_RST;
      cfg_r.tolerance_y     <= crg_pkg::TOL_RST;
      cfg_r.order_guard_on  <= crg_pkg::ORDER_ON_RST;
      cfg_r.order_gap_ms    <= crg_pkg::ORDER_GAP_RST;
    end else if (wr_en) begin
      unique case (ix)
        crg_pkg::REG_DOUBLE_CLICK: cfg_r.double_click_ms <= pwdata[15:0];
        crg_pkg::REG_TOL_X:        cfg_r.tolerance_x     <= pwdata[7:0];
        crg_pkg::REG_TOL_Y:        cfg_r.tolerance_y     <= pwdata[7:0];
        crg_pkg::REG_ORDER_ON:     cfg_r.order_guard_on  <= pwdata[0];
        crg_pkg::REG_ORDER_GAP:    cfg_r.order_gap_ms    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ix)
      crg_pkg::REG_DOUBLE_CLICK: prdata = {16'd0, cfg_r.double_click_ms};
      crg_pkg::REG_TOL_X:        prdata = {24'd0, cfg_r.tolerance_x};
      crg_pkg::REG_TOL_Y:        prdata = {24'd0, cfg_r.tolerance_y};
      crg_pkg::REG_ORDER_ON:     prdata = {31'd0, cfg_r.order_guard_on};
      crg_pkg::REG_ORDER_GAP:    prdata = {16'd0, cfg_r.order_gap_ms};
      default:                   prdata = 32'd0;
    endcase
  end

endmodule

// ===== src/crg_core.sv =====
// ----------------------------------------------------------------------------
// Click rate gate decision core
// Holds pointer and press history and decides each press in one pass.
// ----------------------------------------------------------------------------
module crg_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic               func,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic               is_mouse,
  input  logic               block_double,
  input  logic [31:0]        now_ms,
  input  crg_pkg::cfg_t      cfg,
  output logic               push,
  output crg_pkg::res_t      res
);

  logic signed [15:0] pointer_x_r, pointer_y_r, press_x_r, press_y_r;
  logic [31:0]        last_press_time_r, last_mouse_time_r;

  logic signed [16:0] dx, dy;
  logic [16:0]        adx, ady;
  logic               moved, last_was_mouse;
  logic [15:0]        order_wait, dbl_wait;
  logic               order_hold, dbl_hold, is_press;

  assign is_press = (func == crg_pkg::FUNC_PRESS);

  assign dx  = {pointer_x_r[15], pointer_x_r} - {press_x_r[15], press_x_r};
  assign dy  = {pointer_y_r[15], pointer_y_r} - {press_y_r[15], press_y_r};
  assign adx = dx[16] ? 17'(-dx) : 17'(dx);
  assign ady = dy[16] ? 17'(-dy) : 17'(dy);
  assign moved = (adx > {9'd0, cfg.tolerance_x}) || (ady > {9'd0, cfg.tolerance_y});

  // The last press was a mouse press when both time stamps agree.
  assign last_was_mouse = (last_press_time_r == last_mouse_time_r);

  assign order_wait = crg_pkg::gap_wait(now_ms, last_press_time_r, cfg.order_gap_ms);
  assign dbl_wait   = crg_pkg::gap_wait(now_ms, last_mouse_time_r, cfg.double_click_ms);

  assign order_hold = cfg.order_guard_on && (is_mouse != last_was_mouse) &&
                      (order_wait != 16'd0);
  assign dbl_hold   = is_mouse && block_double && !moved && (dbl_wait != 16'd0);

  assign push = take && is_press;

  always_comb begin
    if (order_hold) begin
      res.accepted = 1'b0;
      res.wait_ms  = order_wait;
    end else if (dbl_hold) begin
      res.accepted = 1'b0;
      res.wait_ms  = dbl_wait;
    end else begin
      res.accepted = 1'b1;
      res.wait_ms  = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pointer_x_r       <= '0;
      pointer_y_r       <= '0;
      press_x_r         <= '0;
      press_y_r         <= '0;
      last_press_time_r <= '0;
      last_mouse_time_r <= '0;
    end else if (take) begin
      if (!is_press) begin
        pointer_x_r <= pos_x;
        pointer_y_r <= pos_y;
      end else if (res.accepted) begin
        last_press_time_r <= now_ms;
        if (is_mouse) begin
          last_mouse_time_r <= now_ms;
          press_x_r         <= pointer_x_r;
          press_y_r         <= pointer_y_r;
        end
      end
    end
  end

endmodule

// ===== src/crg_obuf.sv =====
// ----------------------------------------------------------------------------
// Click rate gate result buffer
// Two-entry result queue: output register plus skid entry.
// ----------------------------------------------------------------------------
module crg_obuf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  crg_pkg::res_t push_res,
  output logic          space,
  output logic          out_valid,
  input  logic          out_ready,
  output crg_pkg::res_t out_res
);

  logic          head_vld_r, head_vld_nxt, tail_vld_r, tail_vld_nxt;
  crg_pkg::res_t head_r, head_nxt, tail_r, tail_nxt;
  logic          pop;

  assign pop       = head_vld_r && out_ready;
  assign space     = !tail_vld_r;
  assign out_valid = head_vld_r;
  assign out_res   = head_r;

  always_comb begin
    head_vld_nxt = head_vld_r;
    head_nxt     = head_r;
    tail_vld_nxt = tail_vld_r;
    tail_nxt     = tail_r;
    if (pop) begin
      head_vld_nxt = tail_vld_r;
      head_nxt     = tail_r;
      tail_vld_nxt = 1'b0;
    end
    if (push) begin
      if (!head_vld_nxt) begin
        head_vld_nxt = 1'b1;
        head_nxt     = push_res;
      end else begin
        tail_vld_nxt = 1'b1;
        tail_nxt     = push_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      tail_vld_r <= 1'b0;
    end else begin
      head_vld_r <= head_vld_nxt;
      tail_vld_r <= tail_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule

// ===== src/click_rate_gate.sv =====
// ----------------------------------------------------------------------------
// Click rate gate
// Holds back key and button presses that come too soon, by time and position.
// ----------------------------------------------------------------------------
// Usage: requests arrive on in_ch, a valid/ready channel. A request with func
// clear is a pointer move; it only records the position and yields no result.
// A request with func set is a press; it yields exactly one result on out_ch,
// either accepted with a wait of zero, or refused with the milliseconds still
// to wait. The press history is only updated by accepted presses.
// The timings and tolerances live in an APB-style register bank; the user is
// to write them while the block is idle, which the block does not enforce. They
// take effect for the next request. A taken press has its result registered in
// the output register, or in the skid entry if that is held. One request per
// cycle while the skid entry is free, set by the single-pass decision logic.
// Stalls: results sit in a two-entry queue (output register plus skid entry),
// so a request is still taken while one result waits; in_ch.ready falls only
// once both entries are full.
// Reset (synchronous, rst_n low): registers return to their defaults, the
// pointer and press history clear to zero and the result queue empties.
// ----------------------------------------------------------------------------
`include "click_rate_gate_assert.svh"

module click_rate_gate (
  input  logic                       clk,
  input  logic                       rst_n,
  crg_in_if.sink                     in_ch,
  crg_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [crg_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  crg_pkg::cfg_t cfg;
  crg_pkg::res_t core_res;
  crg_pkg::res_t out_res;
  logic          space;
  logic          take;
  logic          push;

  // A request is taken whenever the skid entry is free.
  assign in_ch.ready = space;
  assign take        = in_ch.valid && space;

  crg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  crg_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .func         (in_ch.func),
    .pos_x        (in_ch.pos_x),
    .pos_y        (in_ch.pos_y),
    .is_mouse     (in_ch.is_mouse),
    .block_double (in_ch.block_double),
    .now_ms       (in_ch.now_ms),
    .cfg          (cfg),
    .push         (push),
    .res          (core_res)
  );

  crg_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_res  (core_res),
    .space     (space),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.accepted = out_res.accepted;
  assign out_ch.wait_ms  = out_res.wait_ms;

  // An accepted press always reports no wait, a refused one always some wait.
  `CRG_ASSERT_NOW(a_accept_no_wait, out_ch.valid && out_ch.accepted, out_ch.wait_ms == 16'd0)
  `CRG_ASSERT_NOW(a_refuse_has_wait, out_ch.valid && !out_ch.accepted, out_ch.wait_ms != 16'd0)
  // A taken press must be visible on the result side in the next cycle.
  `CRG_ASSERT_NEXT(a_press_gives_result, take && in_ch.func == crg_pkg::FUNC_PRESS, out_ch.valid)
  // A full queue refuses new requests and still offers a result.
  `CRG_ASSERT_NOW(a_full_has_head, !space, out_ch.valid && !in_ch.ready)

endmodule
